### rtl/core/pqdu_pkg.sv
package pqdu_pkg;

    localparam int QUANT_COUNT = 8;
    localparam int CFG_IDX_W   = 4;

    localparam logic [1:0] QT_U8  = 2'd0;
    localparam logic [1:0] QT_U16 = 2'd1;
    localparam logic [1:0] QT_S8  = 2'd2;
    localparam logic [1:0] QT_S16 = 2'd3;

    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  setting_select;
        logic        single_only;
        logic        fp_enabled;
        logic [31:0] first_value;
        logic [31:0] second_value;
    } t_in;

    typedef struct packed {
        logic [31:0] first_result;
        logic [31:0] second_result;
        logic        fp_unavailable;
    } t_out;

    typedef struct packed {
        logic              store;
        logic              single;
        logic              fpen;
        logic              qint;
        logic [1:0]        qtype;
        logic signed [6:0] scale;
    } t_ctl;

    typedef struct packed {
        logic              sgn;
        logic              nan;
        logic              inf;
        logic              zero;
        logic [21:0]       nan_frac;
        logic signed [9:0] expo;
        logic [23:0]       man;
    } t_unp;

    typedef struct packed {
        logic              sgn;
        logic              nan;
        logic              inf;
        logic              zero;
        logic              sub;
        logic              big;
        logic              tiny;
        logic [21:0]       nan_frac;
        logic signed [9:0] expo;
        logic [23:0]       man;
        logic [4:0]        dsh;
        logic [4:0]        sh;
    } t_scl;

    function automatic logic [4:0] lzc24(input logic [23:0] x);
        logic [4:0] cnt;
        cnt = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) begin
                cnt = 5'(23 - i);
            end
        end
        return cnt;
    endfunction

endpackage

### rtl/core/pqdu_unpack.sv
module pqdu_unpack
    import pqdu_pkg::*;
(
    input  logic [31:0] i_raw,
    input  logic        i_is_int,
    input  logic [1:0]  i_qtype,
    output t_unp        o_unp
);
    logic [7:0]  expf;
    logic [22:0] frac;
    logic [15:0] mag;
    logic        neg;
    logic [23:0] x;
    logic [4:0]  c;

    always_comb begin
        expf = i_raw[30:23];
        frac = i_raw[22:0];
        mag  = 16'd0;
        neg  = 1'b0;
        case (i_qtype)
            QT_U8:  mag = {8'd0, i_raw[7:0]};
            QT_U16: mag = i_raw[15:0];
            QT_S8: begin
                neg = i_raw[7];
                mag = neg ? 16'(9'd256 - {1'b0, i_raw[7:0]}) : {8'd0, i_raw[7:0]};
            end
            QT_S16: begin
                neg = i_raw[15];
                mag = neg ? 16'(17'h10000 - {1'b0, i_raw[15:0]}) : i_raw[15:0];
            end
            default: mag = 16'd0;
        endcase

        if (i_is_int) begin
            x = {mag, 8'd0};
        end else begin
            x = {1'b0, frac};
        end
        c = lzc24(x);

        o_unp          = '0;
        o_unp.nan_frac = frac[21:0];
        if (i_is_int) begin
            o_unp.sgn  = neg;
            o_unp.zero = (mag == 16'd0);
            o_unp.man  = x << c;
            o_unp.expo = 10'sd15 - $signed({5'd0, c});
        end else begin
            o_unp.sgn  = i_raw[31];
            o_unp.nan  = (expf == 8'hff) && (frac != 23'd0);
            o_unp.inf  = (expf == 8'hff) && (frac == 23'd0);
            o_unp.zero = (expf == 8'h00) && (frac == 23'd0);
            if (expf == 8'h00) begin
                o_unp.man  = x << c;
                o_unp.expo = -10'sd126 - $signed({5'd0, c});
            end else begin
                o_unp.man  = {1'b1, frac};
                o_unp.expo = $signed({2'b00, expf}) - 10'sd127;
            end
        end
    end
endmodule

### rtl/core/pqdu_scale.sv
module pqdu_scale
    import pqdu_pkg::*;
(
    input  t_unp              i_unp,
    input  logic signed [6:0] i_scale,
    output t_scl              o_scl
);
    logic signed [9:0] e2;
    logic signed [9:0] dfull;

    always_comb begin
        e2    = i_unp.expo + 10'(i_scale);
        dfull = -10'sd126 - e2;

        o_scl          = '0;
        o_scl.sgn      = i_unp.sgn;
        o_scl.nan      = i_unp.nan;
        o_scl.zero     = i_unp.zero;
        o_scl.inf      = i_unp.inf
                         || (!i_unp.nan && !i_unp.zero && (e2 > 10'sd127));
        o_scl.sub      = e2 < -10'sd126;
        o_scl.big      = e2 > 10'sd15;
        o_scl.tiny     = e2 < 10'sd0;
        o_scl.nan_frac = i_unp.nan_frac;
        o_scl.expo     = e2;
        o_scl.man      = i_unp.man;
        o_scl.dsh      = (dfull > 10'sd25) ? 5'd25 : dfull[4:0];
        o_scl.sh       = 5'd23 - e2[4:0];
    end
endmodule

### rtl/core/pqdu_pack.sv
module pqdu_pack
    import pqdu_pkg::*;
(
    input  t_scl        i_scl,
    input  logic        i_to_int,
    input  logic [1:0]  i_qtype,
    output logic [31:0] o_res
);
    logic [48:0] full;
    logic [23:0] keep;
    logic        rnd;
    logic        stk;
    logic [23:0] f;
    logic [7:0]  ebias;
    logic [31:0] fres;
    logic [15:0] mag;
    logic        sat;
    logic [15:0] lim;
    logic [15:0] m;
    logic [31:0] ires;

    always_comb begin
        full  = {i_scl.man, 25'd0} >> i_scl.dsh;
        keep  = full[48:25];
        rnd   = full[24];
        stk   = |full[23:0];
        f     = keep + {23'd0, rnd & (stk | keep[0])};
        ebias = 8'(i_scl.expo + 10'sd127);

        if (i_scl.nan) begin
            fres = {i_scl.sgn, 8'hff, 1'b1, i_scl.nan_frac};
        end else if (i_scl.inf) begin
            fres = {i_scl.sgn, 8'hff, 23'd0};
        end else if (i_scl.zero) begin
            fres = {i_scl.sgn, 31'd0};
        end else if (i_scl.sub) begin
            fres = {i_scl.sgn, 7'd0, f};
        end else begin
            fres = {i_scl.sgn, ebias, i_scl.man[22:0]};
        end

        sat = i_scl.inf || i_scl.big;
        if (i_scl.tiny || sat) begin
            mag = 16'd0;
        end else begin
            mag = 16'(i_scl.man >> i_scl.sh);
        end

        lim  = 16'd0;
        m    = 16'd0;
        ires = 32'd0;
        if (!i_scl.nan && !i_scl.zero) begin
            case (i_qtype)
                QT_U8: begin
                    if (!i_scl.sgn) begin
                        ires = (sat || mag > 16'd255) ? 32'd255 : {16'd0, mag};
                    end
                end
                QT_U16: begin
                    if (!i_scl.sgn) begin
                        ires = sat ? 32'd65535 : {16'd0, mag};
                    end
                end
                QT_S8: begin
                    lim  = i_scl.sgn ? 16'd128 : 16'd127;
                    m    = (sat || mag > lim) ? lim : mag;
                    ires = {24'd0, i_scl.sgn ? 8'(-m) : m[7:0]};
                end
                QT_S16: begin
                    lim  = i_scl.sgn ? 16'd32768 : 16'd32767;
                    m    = (sat || mag > lim) ? lim : mag;
                    ires = {16'd0, i_scl.sgn ? 16'(-m) : m};
                end
                default: ires = 32'd0;
            endcase
        end

        o_res = i_to_int ? ires : fres;
    end
endmodule

### rtl/core/paired_quantize_dequantize_unit_top.sv
// paired quantize/dequantize unit
// input channel: i_in_valid / o_in_stall carry one request (t_in) per cycle,
//   accepted when valid is high and stall is low
// output channel: o_out_valid / i_out_stall carry one result (t_out) per request
// configuration: i_cfg_we writes i_cfg_data into quantization register
//   i_cfg_index (0..7); higher indexes are dropped
// pipeline: three register stages (unpack, scale, pack); o_out_valid rises
//   when an accepted request reaches the pack register
// throughput: one request per cycle, no bubbles while the output is taken
// the three stages advance together; when the output register holds a result
//   and i_out_stall is high, the whole pipe holds and o_in_stall rises
// reset (i_rst_n low, synchronous) clears all valid bits and the eight
//   quantization registers
module paired_quantize_dequantize_unit_top
    import pqdu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    logic [31:0] r_qs [QUANT_COUNT];

    logic en;
    logic r_a_valid, r_b_valid, r_c_valid;
    t_ctl n_a_ctl, r_a_ctl, r_b_ctl;
    t_unp n_a_unp0, n_a_unp1, r_a_unp0, r_a_unp1;
    t_scl n_b_scl0, n_b_scl1, r_b_scl0, r_b_scl1;
    logic [31:0] n_c_res0, n_c_res1;
    t_out n_c_out, r_c_out;
    logic r_c_single, r_c_store;

    logic [31:0]       q;
    logic [2:0]        qt;
    logic [5:0]        qs;
    logic signed [6:0] qs_ext;

    assign en          = !(r_c_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_c_valid;
    assign o_out       = r_c_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUANT_COUNT; i++) begin
                r_qs[i] <= 32'd0;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(QUANT_COUNT))) begin
            r_qs[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        q      = r_qs[i_in.setting_select];
        qt     = i_in.opcode ? q[2:0] : q[18:16];
        qs     = i_in.opcode ? q[13:8] : q[29:24];
        qs_ext = $signed({qs[5], qs});
        n_a_ctl.store  = i_in.opcode;
        n_a_ctl.single = i_in.single_only;
        n_a_ctl.fpen   = i_in.fp_enabled;
        n_a_ctl.qint   = qt[2];
        n_a_ctl.qtype  = qt[1:0];
        n_a_ctl.scale  = i_in.opcode ? qs_ext : -qs_ext;
    end

    pqdu_unpack u_unpack0 (
        .i_raw    (i_in.first_value),
        .i_is_int (!i_in.opcode && qt[2]),
        .i_qtype  (qt[1:0]),
        .o_unp    (n_a_unp0)
    );

    pqdu_unpack u_unpack1 (
        .i_raw    (i_in.second_value),
        .i_is_int (!i_in.opcode && qt[2]),
        .i_qtype  (qt[1:0]),
        .o_unp    (n_a_unp1)
    );

    pqdu_scale u_scale0 (
        .i_unp   (r_a_unp0),
        .i_scale (r_a_ctl.scale),
        .o_scl   (n_b_scl0)
    );

    pqdu_scale u_scale1 (
        .i_unp   (r_a_unp1),
        .i_scale (r_a_ctl.scale),
        .o_scl   (n_b_scl1)
    );

    pqdu_pack u_pack0 (
        .i_scl    (r_b_scl0),
        .i_to_int (r_b_ctl.store && r_b_ctl.qint),
        .i_qtype  (r_b_ctl.qtype),
        .o_res    (n_c_res0)
    );

    pqdu_pack u_pack1 (
        .i_scl    (r_b_scl1),
        .i_to_int (r_b_ctl.store && r_b_ctl.qint),
        .i_qtype  (r_b_ctl.qtype),
        .o_res    (n_c_res1)
    );

    always_comb begin
        n_c_out = '0;
        if (!r_b_ctl.fpen) begin
            n_c_out.fp_unavailable = 1'b1;
        end else begin
            n_c_out.first_result = n_c_res0;
            if (r_b_ctl.single) begin
                n_c_out.second_result = r_b_ctl.store ? 32'd0 : ONE_BITS;
            end else begin
                n_c_out.second_result = n_c_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctl    <= n_a_ctl;
            r_a_unp0   <= n_a_unp0;
            r_a_unp1   <= n_a_unp1;
            r_b_ctl    <= r_a_ctl;
            r_b_scl0   <= n_b_scl0;
            r_b_scl1   <= n_b_scl1;
            r_c_out    <= n_c_out;
            r_c_single <= r_b_ctl.single;
            r_c_store  <= r_b_ctl.store;
        end
    end

    a_unavail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.fp_unavailable
        |-> o_out.first_result == 32'd0 && o_out.second_result == 32'd0)
        else $error("fault result carries data");

    a_single_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_c_single && !o_out.fp_unavailable
        |-> o_out.second_result == (r_c_store ? 32'd0 : ONE_BITS))
        else $error("single request second result wrong");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

### bench/paired_quantize_dequantize_unit_top_tb.sv
`timescale 1ns / 1ps

module paired_quantize_dequantize_unit_top_tb;
    import pqdu_pkg::*;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [2:0] TYPE_U8  = 3'd4;
    localparam logic [2:0] TYPE_U16 = 3'd5;
    localparam logic [2:0] TYPE_S8  = 3'd6;
    localparam logic [2:0] TYPE_S16 = 3'd7;

    localparam int SEL_FLOAT   = 0;
    localparam int SEL_U8      = 1;
    localparam int SEL_U16     = 2;
    localparam int SEL_S8      = 3;
    localparam int SEL_S16_EXT = 4;
    localparam int SEL_RSV_MIN = 5;
    localparam int SEL_ALL_ONE = 6;
    localparam int SEL_FLT_MAX = 7;
    localparam int SEL_BEYOND  = 9;

    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 103;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in                  in_req;
    logic                 out_valid;
    logic                 out_stall;
    t_out                 out_res;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    paired_quantize_dequantize_unit_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    logic [31:0] quant_regs [QUANT_COUNT];
    t_in         pending_reqs [$];
    t_out        expected_results [$];
    int          err_count;
    bit          req_taken;
    int          burst_left;
    int          gap_left;
    int          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("paired_quantize_dequantize_unit_top test failed");
        $finish;
    end

    function automatic int scale_of(input logic [5:0] f);
        return int'(f[4:0]) - (f[5] ? 32 : 0);
    endfunction

    // round m * 2^e to single precision, nearest even
    function automatic logic [31:0] round_single(input bit sgn, input longint unsigned m,
                                                 input int e);
        int              len;
        int              lsb;
        int              sh;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        if (m == 0) begin
            return {sgn, 31'd0};
        end
        len = 0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                len = i + 1;
            end
        end
        lsb = e + len - 24;
        if (lsb < -149) begin
            lsb = -149;
        end
        sh = lsb - e;
        if (sh > 62) begin
            q = 0;
        end else if (sh > 0) begin
            q = m >> sh;
            rem = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 1;
            end
        end else begin
            q = m << (-sh);
        end
        if (q == (64'd1 << 24)) begin
            q = q >> 1;
            lsb = lsb + 1;
        end
        if (q < (64'd1 << 23)) begin
            return {sgn, q[30:0]};
        end
        if (lsb + 150 > 254) begin
            return {sgn, 8'hFF, 23'd0};
        end
        return {sgn, 8'(lsb + 150), q[22:0]};
    endfunction

    function automatic logic [31:0] scale_single(input logic [31:0] b, input int s);
        longint unsigned m;
        int              e;
        if (b[30:23] == 8'hFF) begin
            return (b[22:0] != 0) ? (b | 32'h0040_0000) : b;
        end
        if (b[30:23] == 8'd0) begin
            m = b[22:0];
            e = -149;
        end else begin
            m = {1'b1, b[22:0]};
            e = int'(b[30:23]) - 150;
        end
        return round_single(b[31], m, e + s);
    endfunction

    function automatic logic [31:0] dequantize(input logic [31:0] raw, input logic [2:0] qt,
                                               input int s);
        int v;
        case (qt)
            TYPE_U8:  v = int'(raw[7:0]);
            TYPE_U16: v = int'(raw[15:0]);
            TYPE_S8:  v = int'($signed(raw[7:0]));
            TYPE_S16: v = int'($signed(raw[15:0]));
            default:  return scale_single(raw, -s);
        endcase
        return round_single(v < 0, (v < 0) ? -v : v, -s);
    endfunction

    function automatic logic [31:0] quantize(input logic [31:0] b, input logic [2:0] qt,
                                             input int s);
        logic [31:0] x;
        int          mag;
        int          v;
        x = scale_single(b, s);
        if (qt < TYPE_U8) begin
            return x;
        end
        if (x[30:23] == 8'hFF && x[22:0] != 0) begin
            v = 0;
        end else begin
            if (x[30:23] < 8'd127) begin
                mag = 0;
            end else if (x[30:23] >= 8'd147) begin
                mag = 1 << 20;
            end else begin
                mag = int'({1'b1, x[22:0]} >> (150 - int'(x[30:23])));
            end
            v = x[31] ? -mag : mag;
        end
        case (qt)
            TYPE_U8:  v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            TYPE_U16: v = (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
            TYPE_S8:  v = (v < -128) ? -128 : ((v > 127) ? 127 : v);
            default:  v = (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
        endcase
        return (qt == TYPE_U8 || qt == TYPE_S8) ? (v & 32'hFF) : (v & 32'hFFFF);
    endfunction

    function automatic t_out convert_pair(input t_in r);
        t_out        o;
        logic [31:0] q;
        q = quant_regs[r.setting_select];
        o = '0;
        if (!r.fp_enabled) begin
            o.fp_unavailable = 1'b1;
        end else if (r.opcode == OP_LOAD) begin
            o.first_result  = dequantize(r.first_value, q[18:16], scale_of(q[29:24]));
            o.second_result = r.single_only ? ONE_BITS
                            : dequantize(r.second_value, q[18:16], scale_of(q[29:24]));
        end else begin
            o.first_result  = quantize(r.first_value, q[2:0], scale_of(q[13:8]));
            o.second_result = r.single_only ? 32'd0
                            : quantize(r.second_value, q[2:0], scale_of(q[13:8]));
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic write_quant(input int idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        if (idx < QUANT_COUNT) begin
            quant_regs[idx] = data;
        end
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_req(input logic op, input int sel, input logic single,
                           input logic fpen, input logic [31:0] v0, input logic [31:0] v1);
        t_in r;
        r.opcode         = op;
        r.setting_select = 3'(sel);
        r.single_only    = single;
        r.fp_enabled     = fpen;
        r.first_value    = v0;
        r.second_value   = v1;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] specials [10];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFFA0_0001, 32'h0000_0001, 32'h807F_FFFF,
                     32'h7F7F_FFFF, 32'h3F80_0000};
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return specials[$urandom_range(0, 9)];
            default: return {1'($urandom), 8'($urandom_range(115, 150)), 23'($urandom)};
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                in_valid <= 1'b1;
                in_req   <= pending_reqs[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 49) == 0) begin
            stall_mode = $urandom_range(0, 2);
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom);
            default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // acceptance and result check
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(convert_pair(in_req));
                void'(pending_reqs.pop_front());
                req_taken = 1'b1;
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", out_res.first_result, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_res.first_result !== want.first_result) begin
                        report_mismatch("first_result", out_res.first_result,
                                        want.first_result);
                    end
                    if (out_res.second_result !== want.second_result) begin
                        report_mismatch("second_result", out_res.second_result,
                                        want.second_result);
                    end
                    if (out_res.fp_unavailable !== want.fp_unavailable) begin
                        report_mismatch("fp_unavailable", 32'(out_res.fp_unavailable),
                                        32'(want.fp_unavailable));
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] q;
        int          sel;
        logic        op;
        err_count  = 0;
        req_taken  = 1'b0;
        burst_left = 8;
        gap_left   = 0;
        stall_mode = 0;
        in_valid   = 1'b0;
        in_req     = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        for (int i = 0; i < QUANT_COUNT; i++) begin
            quant_regs[i] = 32'd0;
        end
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers straight out of reset
        add_req(OP_LOAD, SEL_FLOAT, 1'b0, 1'b1, 32'h3F80_0000, 32'h7FA0_0000);
        add_req(OP_STORE, SEL_S8, 1'b0, 1'b1, 32'h7F80_0000, 32'h8000_0000);
        drain();

        write_quant(SEL_FLOAT, 32'h0000_0000);
        write_quant(SEL_U8, 32'h0004_0004);
        write_quant(SEL_U16, 32'h0005_0005);
        write_quant(SEL_S8, 32'h0006_0006);
        write_quant(SEL_S16_EXT, 32'h1F07_2007);
        write_quant(SEL_RSV_MIN, 32'h2001_2001);
        write_quant(SEL_ALL_ONE, 32'hFFFF_FFFF);
        write_quant(SEL_FLT_MAX, 32'h1F00_1F00);
        write_quant(SEL_BEYOND, 32'hFFFF_FFFF);
        end_writes();

        add_req(OP_LOAD, SEL_U8, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h1234_5678);
        add_req(OP_STORE, SEL_U16, 1'b1, 1'b0, 32'h4396_0000, 32'hFFFF_FFFF);
        add_req(OP_LOAD, SEL_U8, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        add_req(OP_LOAD, SEL_U8, 1'b1, 1'b1, 32'h0000_0080, 32'hFFFF_FFFF);
        add_req(OP_LOAD, SEL_U16, 1'b0, 1'b1, 32'h1234_FFFF, 32'h0000_8000);
        add_req(OP_LOAD, SEL_S8, 1'b0, 1'b1, 32'h0000_0080, 32'h0000_007F);
        add_req(OP_LOAD, SEL_S16_EXT, 1'b0, 1'b1, 32'h0000_8000, 32'h0000_7FFF);
        add_req(OP_STORE, SEL_U8, 1'b0, 1'b1, 32'h4396_0000, 32'hC0A0_0000);
        add_req(OP_STORE, SEL_U8, 1'b0, 1'b1, 32'h7FC0_0000, 32'h437F_E666);
        add_req(OP_STORE, SEL_U16, 1'b0, 1'b1, 32'h4788_B800, 32'h477F_FF80);
        add_req(OP_STORE, SEL_S8, 1'b0, 1'b1, 32'hC348_0000, 32'h42FF_6666);
        add_req(OP_STORE, SEL_S8, 1'b1, 1'b1, 32'hC300_E666, 32'h3F80_0000);
        add_req(OP_STORE, SEL_S16_EXT, 1'b0, 1'b1, 32'h60AD_78EC, 32'hFFC0_0000);
        add_req(OP_STORE, SEL_ALL_ONE, 1'b0, 1'b1, 32'hC788_B800, 32'h7F80_0000);
        add_req(OP_STORE, SEL_RSV_MIN, 1'b0, 1'b1, 32'h0000_0003, 32'h8000_0001);
        add_req(OP_STORE, SEL_RSV_MIN, 1'b1, 1'b1, 32'h4F80_0000, 32'h0000_0000);
        add_req(OP_STORE, SEL_FLT_MAX, 1'b0, 1'b1, 32'h7F00_0000, 32'h0000_0001);
        add_req(OP_LOAD, SEL_RSV_MIN, 1'b0, 1'b1, 32'h7E00_0000, 32'h0000_0001);
        add_req(OP_LOAD, SEL_FLT_MAX, 1'b0, 1'b1, 32'h0080_0001, 32'h3FC0_0001);
        add_req(OP_LOAD, SEL_ALL_ONE, 1'b1, 1'b1, 32'h0000_8000, 32'h0000_0000);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int r = 0; r < QUANT_COUNT; r++) begin
                q = $urandom;
                if (p == RAND_PHASES - 1) begin
                    q = {2'b00, ((r % 2) ? 6'h1F : 6'h20), 5'd0, 3'(r), 2'b00,
                         ((r % 2) ? 6'h20 : 6'h1F), 5'd0, 3'(7 - r)};
                end else if ($urandom_range(0, 1) == 0) begin
                    q[29:24] = 6'($urandom_range(0, 8) - 4);
                    q[13:8]  = 6'($urandom_range(0, 8) - 4);
                end
                write_quant(r, q);
            end
            write_quant($urandom_range(QUANT_COUNT, 15), $urandom);
            end_writes();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op  = 1'($urandom);
                sel = $urandom_range(0, QUANT_COUNT - 1);
                add_req(op, sel, ($urandom_range(0, 3) == 0), ($urandom_range(0, 9) != 0),
                        pick_value(), pick_value());
            end
            drain();
        end

        if (err_count == 0) begin
            $display("paired_quantize_dequantize_unit_top test passed");
        end else begin
            $display("paired_quantize_dequantize_unit_top test failed");
        end
        $finish;
    end

endmodule
